// ===== src/gtu_pkg.sv =====
// ----------------------------------------------------------------------------
// gtu_pkg: shared types and constants for the GPS-time to UTC calendar unit
// Field widths, epoch constants, reciprocal constants for the constant
// dividers and the calendar start-day tables.
// ----------------------------------------------------------------------------
package gtu_pkg;

  localparam int WEEK_W = 13;
  localparam int TOW_W  = 30;
  localparam int OFS_W  = 6;
  localparam int SEC_W  = 33;   // seconds since 1970, max about 5.3e9

  localparam logic [OFS_W-1:0] GPS_MINUS_UTC_RST = 6'd18;
  localparam logic [SEC_W-1:0] GPS_EPOCH_UNIX    = 33'd315964800;
  localparam logic [SEC_W-1:0] SEC_PER_WEEK      = 33'd604800;
  localparam logic [11:0]      BASE_YEAR         = 12'd1970;

  // x / D == (x * R) >> S, low by at most one; fixed up after the multiply
  localparam int unsigned MS_DIV      = 1000;
  localparam int unsigned MS_RECIP    = 1099511627;
  localparam int unsigned MS_SHIFT    = 40;
  localparam int unsigned DAY_DIV     = 675;        // 86400 = 675 << 7
  localparam int unsigned DAY_RECIP   = 101806632;
  localparam int unsigned DAY_SHIFT   = 36;
  localparam int unsigned CYC_DIV     = 1461;
  localparam int unsigned CYC_RECIP   = 2939744;
  localparam int unsigned CYC_SHIFT   = 32;
  localparam int unsigned HR_DIV      = 3600;
  localparam int unsigned HR_RECIP    = 1193046;
  localparam int unsigned HR_SHIFT    = 32;
  localparam int unsigned MIN_DIV     = 60;
  localparam int unsigned MIN_RECIP   = 279620;
  localparam int unsigned MIN_SHIFT   = 24;

  // load strobes for the two register stages of a divider
  typedef struct packed {
    logic a;   // multiply stage
    logic b;   // correction stage
  } gtu_ld_t;

  // first day of year k within the four-year cycle (third year is leap)
  function automatic logic [10:0] year_start(input logic [1:0] yr);
    logic [10:0] d;
    case (yr)
      2'd0:    d = 11'd0;
      2'd1:    d = 11'd365;
      2'd2:    d = 11'd730;
      default: d = 11'd1096;
    endcase
    return d;
  endfunction

  // first day of month m (0 = January) within its year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && m >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== src/gtu_cdiv.sv =====
// ----------------------------------------------------------------------------
// gtu_cdiv: two-stage divide by a constant
// Stage a multiplies by a truncated reciprocal, stage b applies the single
// correction step and gives quotient and remainder.
// ----------------------------------------------------------------------------
module gtu_cdiv
  import gtu_pkg::*;
#(
  parameter int          XW      = TOW_W,
  parameter int          QW      = 21,
  parameter int          RW      = 10,
  parameter int          MW      = 31,
  parameter int unsigned DIVISOR = MS_DIV,
  parameter int unsigned RECIP   = MS_RECIP,
  parameter int unsigned SHIFT   = MS_SHIFT
) (
  input  logic          clk,
  input  gtu_ld_t       ld,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  localparam int PW = XW + MW;

  logic [PW-1:0] prod;
  logic [XW-1:0] x_r;
  logic [QW-1:0] q0_r;
  logic [XW-1:0] qd;
  logic [XW-1:0] r0;
  logic          fix;
  logic [QW-1:0] q_r, q_nxt;
  logic [RW-1:0] r_r, r_nxt;

  assign prod = PW'(x) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (ld.a) begin
      x_r  <= x;
      q0_r <= prod[SHIFT+QW-1:SHIFT];
    end
  end

  // estimate is exact or one low
  assign qd  = XW'(q0_r) * XW'(DIVISOR);
  assign r0  = x_r - qd;
  assign fix = (r0 >= XW'(DIVISOR));

  always_comb begin
    q_nxt = fix ? q0_r + QW'(1) : q0_r;
    r_nxt = fix ? RW'(r0 - XW'(DIVISOR)) : RW'(r0);
  end

  always_ff @(posedge clk) begin
    if (ld.b) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule

// ===== src/gps_time_to_utc_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_utc_calendar_unit: GPS week / time of week to UTC date and time
// Nine-stage pipeline of constant dividers and calendar table lookups.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; every stage
//   stalls independently, so bubbles collapse under output back-pressure.
// Reset (rst_n low, synchronous): clears all stage valid bits and loads the
//   leap offset with 18 s. No clearing pass.
module gps_time_to_utc_calendar_unit
  import gtu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [OFS_W-1:0]  cfg_gps_minus_utc,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WEEK_W-1:0] in_gps_week,
  input  logic [TOW_W-1:0]  in_tow_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day_of_month,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic [9:0]        out_millisecond
);

  localparam int NS = 9;

  logic [OFS_W-1:0] ofs_r;
  logic [NS-1:0]    v_r, v_nxt;
  logic [NS-1:0]    en;

  // ---- config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= GPS_MINUS_UTC_RST;
    end else if (cfg_we) begin
      ofs_r <= cfg_gps_minus_utc;
    end
  end

  // ---- stage control: a stage loads when empty or when it drains
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // ---- stages 1-2: tow / 1000, week seconds
  logic [SEC_W-1:0] wk_sec;
  logic [SEC_W-1:0] wk_sec_s1_r, wk_sec_s2_r;
  logic [20:0]      tow_s;
  logic [9:0]       ms_s2;

  assign wk_sec = SEC_W'(in_gps_week) * SEC_PER_WEEK;

  gtu_cdiv #(
    .XW(TOW_W), .QW(21), .RW(10), .MW(31),
    .DIVISOR(MS_DIV), .RECIP(MS_RECIP), .SHIFT(MS_SHIFT)
  ) u_div_ms (
    .clk(clk), .ld('{a: en[0], b: en[1]}), .x(in_tow_ms), .q(tow_s), .r(ms_s2)
  );

  always_ff @(posedge clk) begin
    if (en[0]) wk_sec_s1_r <= wk_sec;
    if (en[1]) wk_sec_s2_r <= wk_sec_s1_r;
  end

  // ---- stage 3: UTC seconds since 1970
  logic [SEC_W:0]   t_sum;
  logic [SEC_W-1:0] t_s3_r;
  logic [9:0]       ms_s3_r, ms_s4_r, ms_s5_r, ms_s6_r, ms_s7_r, ms_s8_r, ms_s9_r;

  assign t_sum = (SEC_W+1)'(GPS_EPOCH_UNIX) + (SEC_W+1)'(wk_sec_s2_r)
               + (SEC_W+1)'(tow_s) - (SEC_W+1)'(ofs_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_s3_r  <= t_sum[SEC_W-1:0];
      ms_s3_r <= ms_s2;
    end
  end

  // ---- stages 4-5: days and second of day (86400 = 675 * 128)
  logic [15:0] days_s5;
  logic [9:0]  sod_hi_s5;
  logic [6:0]  sod_lo_s4_r, sod_lo_s5_r;
  logic [16:0] sod_s5;

  gtu_cdiv #(
    .XW(SEC_W-7), .QW(16), .RW(10), .MW(27),
    .DIVISOR(DAY_DIV), .RECIP(DAY_RECIP), .SHIFT(DAY_SHIFT)
  ) u_div_day (
    .clk(clk), .ld('{a: en[3], b: en[4]}), .x(t_s3_r[SEC_W-1:7]),
    .q(days_s5), .r(sod_hi_s5)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sod_lo_s4_r <= t_s3_r[6:0];
      ms_s4_r     <= ms_s3_r;
    end
    if (en[4]) begin
      sod_lo_s5_r <= sod_lo_s4_r;
      ms_s5_r     <= ms_s4_r;
    end
  end

  assign sod_s5 = {sod_hi_s5, sod_lo_s5_r};

  // ---- stages 6-7: four-year cycles, hours
  logic [5:0]  cyc_s7;
  logic [10:0] dcyc_s7;
  logic [4:0]  hour_s7;
  logic [11:0] soh_s7;

  gtu_cdiv #(
    .XW(16), .QW(6), .RW(11), .MW(22),
    .DIVISOR(CYC_DIV), .RECIP(CYC_RECIP), .SHIFT(CYC_SHIFT)
  ) u_div_cyc (
    .clk(clk), .ld('{a: en[5], b: en[6]}), .x(days_s5), .q(cyc_s7), .r(dcyc_s7)
  );

  gtu_cdiv #(
    .XW(17), .QW(5), .RW(12), .MW(21),
    .DIVISOR(HR_DIV), .RECIP(HR_RECIP), .SHIFT(HR_SHIFT)
  ) u_div_hr (
    .clk(clk), .ld('{a: en[5], b: en[6]}), .x(sod_s5), .q(hour_s7), .r(soh_s7)
  );

  always_ff @(posedge clk) begin
    if (en[5]) ms_s6_r <= ms_s5_r;
    if (en[6]) ms_s7_r <= ms_s6_r;
  end

  // ---- stage 8: year within cycle, day of year; minutes start
  logic [1:0]  yr;
  logic [1:0]  yr_s8_r;
  logic [8:0]  doy_s8_r;
  logic [5:0]  cyc_s8_r;
  logic [4:0]  hour_s8_r;
  logic [5:0]  min_s9;
  logic [5:0]  sec_s9;

  assign yr = 2'(dcyc_s7 >= year_start(2'd1)) + 2'(dcyc_s7 >= year_start(2'd2))
            + 2'(dcyc_s7 >= year_start(2'd3));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      yr_s8_r   <= yr;
      doy_s8_r  <= 9'(dcyc_s7 - year_start(yr));
      cyc_s8_r  <= cyc_s7;
      hour_s8_r <= hour_s7;
      ms_s8_r   <= ms_s7_r;
    end
  end

  gtu_cdiv #(
    .XW(12), .QW(6), .RW(6), .MW(19),
    .DIVISOR(MIN_DIV), .RECIP(MIN_RECIP), .SHIFT(MIN_SHIFT)
  ) u_div_min (
    .clk(clk), .ld('{a: en[7], b: en[8]}), .x(soh_s7), .q(min_s9), .r(sec_s9)
  );

  // ---- stage 9: month, day of month, year
  logic       leap;
  logic [3:0] mon;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  dom_r;
  logic [4:0]  hour_r;

  assign leap = (yr_s8_r == 2'd2);

  always_comb begin
    mon = '0;
    for (int m = 1; m < 12; m++) begin
      if (doy_s8_r >= month_start(4'(m), leap)) begin
        mon = mon + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      year_r  <= BASE_YEAR + 12'({cyc_s8_r, yr_s8_r});
      month_r <= mon + 4'd1;
      dom_r   <= 5'(doy_s8_r - month_start(mon, leap) + 9'd1);
      hour_r  <= hour_s8_r;
      ms_s9_r <= ms_s8_r;
    end
  end

  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = dom_r;
  assign out_hour         = hour_r;
  assign out_minute       = min_s9;
  assign out_second       = sec_s9;
  assign out_millisecond  = ms_s9_r;

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31 &&
                   out_year >= 12'd1980))
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second <= 6'd59 && out_millisecond <= 10'd999))
    else $error("time of day out of range");
`endif

endmodule

// ===== dv/utc_date_board_pkg.sv =====
// ----------------------------------------------------------------------------
// utc_date_board_pkg: expected-date store for the GPS-time to UTC unit
// Holds its own copy of the leap offset, turns every accepted GPS week and
// time of week into the expected UTC date and time, and checks the words
// that leave the block against them in order.
// ----------------------------------------------------------------------------
package utc_date_board_pkg;

  import gtu_pkg::*;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
  } utc_date_t;

  localparam longint unsigned UNIX_AT_GPS_EPOCH = 64'd315964800;
  localparam longint unsigned WEEK_SECONDS      = 64'd604800;
  localparam longint unsigned DAY_SECONDS       = 64'd86400;
  localparam longint unsigned QUAD_YEAR_DAYS    = 64'd1461;
  localparam int unsigned     FIRST_YEAR        = 1970;
  localparam int unsigned     MONTH_DAYS [12]   = '{31, 28, 31, 30, 31, 30,
                                                    31, 31, 30, 31, 30, 31};
  localparam int unsigned     REPORT_LIMIT      = 10;

  class utc_date_board;
    logic [OFS_W-1:0] leap_s;
    utc_date_t        awaited[$];
    int unsigned      words_checked;
    int unsigned      bad_words;
    int unsigned      orphan_words;

    function new();
      leap_s        = GPS_MINUS_UTC_RST;
      words_checked = 0;
      bad_words     = 0;
      orphan_words  = 0;
    endfunction

    // seconds since 1970, then 4-year cycles; the third year of a cycle is leap
    function utc_date_t gps_to_utc(logic [WEEK_W-1:0] week, logic [TOW_W-1:0] tow);
      longint unsigned secs, days, sod, day;
      int unsigned     cyc, yr, mon, mlen;
      utc_date_t       d;
      secs = UNIX_AT_GPS_EPOCH + 64'(week) * WEEK_SECONDS + 64'(tow) / 64'd1000
             - 64'(leap_s);
      days = secs / DAY_SECONDS;
      sod  = secs % DAY_SECONDS;
      cyc  = int'(days / QUAD_YEAR_DAYS);
      day  = days % QUAD_YEAR_DAYS;
      yr   = 0;
      while (yr < 3 && day >= ((yr == 2) ? 366 : 365)) begin
        day = day - ((yr == 2) ? 366 : 365);
        yr++;
      end
      mon = 0;
      mlen = MONTH_DAYS[0];
      while (mon < 11 && day >= mlen) begin
        day = day - mlen;
        mon++;
        mlen = MONTH_DAYS[mon] + ((mon == 1 && yr == 2) ? 1 : 0);
      end
      d.year   = 12'(FIRST_YEAR + cyc * 4 + yr);
      d.month  = 4'(mon + 1);
      d.mday   = 5'(day + 1);
      d.hour   = 5'(sod / 3600);
      d.minute = 6'((sod % 3600) / 60);
      d.second = 6'(sod % 60);
      d.msec   = 10'(tow % 1000);
      return d;
    endfunction

    function void note_input(logic [WEEK_W-1:0] week, logic [TOW_W-1:0] tow);
      awaited.push_back(gps_to_utc(week, tow));
    endfunction

    function void check_output(utc_date_t got);
      utc_date_t want;
      string     diff;
      diff = "";
      if (awaited.size() == 0) begin
        orphan_words++;
        if (bad_words + orphan_words <= REPORT_LIMIT)
          $display("ERROR: unexpected result word %0d-%0d-%0d %0d:%0d:%0d.%0d",
                   got.year, got.month, got.mday, got.hour, got.minute,
                   got.second, got.msec);
        return;
      end
      want = awaited.pop_front();
      words_checked++;
      if (got.year   != want.year)   diff = {diff, " year"};
      if (got.month  != want.month)  diff = {diff, " month"};
      if (got.mday   != want.mday)   diff = {diff, " day_of_month"};
      if (got.hour   != want.hour)   diff = {diff, " hour"};
      if (got.minute != want.minute) diff = {diff, " minute"};
      if (got.second != want.second) diff = {diff, " second"};
      if (got.msec   != want.msec)   diff = {diff, " millisecond"};
      if (diff != "") begin
        bad_words++;
        if (bad_words + orphan_words <= REPORT_LIMIT)
          $display({"ERROR: word %0d wrong in%s: expected %0d-%0d-%0d %0d:%0d:%0d.%0d,",
                    " got %0d-%0d-%0d %0d:%0d:%0d.%0d"},
                   words_checked, diff,
                   want.year, want.month, want.mday, want.hour, want.minute,
                   want.second, want.msec,
                   got.year, got.month, got.mday, got.hour, got.minute,
                   got.second, got.msec);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// ===== dv/gps_time_to_utc_calendar_unit_test.sv =====
// ----------------------------------------------------------------------------
// gps_time_to_utc_calendar_unit_test: testbench for the GPS-time to UTC unit
// Directed words at day, year and leap-day edges and at the field extremes,
// then random words over several leap offsets, random input gaps and random
// output back-pressure save in the last run, all checked against a predictor.
// ----------------------------------------------------------------------------
module gps_time_to_utc_calendar_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gtu_pkg::*;
  import utc_date_board_pkg::*;

  localparam int unsigned      PIPE_DRAIN = 16;
  localparam logic [TOW_W-1:0] TOW_MAX    = {TOW_W{1'b1}};
  localparam logic [WEEK_W-1:0] WEEK_MAX  = {WEEK_W{1'b1}};
  localparam int unsigned      WEEK_LAST  = 6199;
  localparam int unsigned      TOW_WEEK   = 604800000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [OFS_W-1:0]  cfg_gps_minus_utc = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WEEK_W-1:0] in_gps_week = '0;
  logic [TOW_W-1:0]  in_tow_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [11:0]       out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day_of_month;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;
  logic [9:0]        out_millisecond;

  utc_date_board dates;
  bit            calm = 1'b0;
  int unsigned   words_sent = 0;
  int unsigned   offsets_used = 1;
  int unsigned   past_week_tows = 0;
  int unsigned   late_weeks = 0;

  gps_time_to_utc_calendar_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_gps_minus_utc (cfg_gps_minus_utc),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_gps_week       (in_gps_week),
    .in_tow_ms         (in_tow_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_year          (out_year),
    .out_month         (out_month),
    .out_day_of_month  (out_day_of_month),
    .out_hour          (out_hour),
    .out_minute        (out_minute),
    .out_second        (out_second),
    .out_millisecond   (out_millisecond)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAIL gps_time_to_utc_calendar_unit");
    $finish;
  end

  // output back-pressure: ready runs, then stall bursts
  always begin
    @(posedge clk);
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      dates.check_output('{out_year, out_month, out_day_of_month, out_hour,
                           out_minute, out_second, out_millisecond});
    end
  end

  task automatic send_word(input logic [WEEK_W-1:0] week, input logic [TOW_W-1:0] tow);
    in_valid    <= 1'b1;
    in_gps_week <= week;
    in_tow_ms   <= tow;
    do @(posedge clk); while (!in_ready);
    dates.note_input(week, tow);
    words_sent++;
    if (tow >= TOW_WEEK) past_week_tows++;
    if (week > WEEK_LAST) late_weeks++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (dates.pending() != 0) @(posedge clk);
  endtask

  // offset changes only with the pipeline empty
  task automatic set_leap_offset(input logic [OFS_W-1:0] leap);
    wait_results_done();
    repeat (PIPE_DRAIN) @(posedge clk);
    cfg_we            <= 1'b1;
    cfg_gps_minus_utc <= leap;
    @(posedge clk);
    cfg_we <= 1'b0;
    dates.leap_s = leap;
    offsets_used++;
  endtask

  task automatic random_words(input int unsigned count, input int unsigned pause_at);
    logic [WEEK_W-1:0] week;
    logic [TOW_W-1:0]  tow;
    int unsigned       pick;
    for (int unsigned i = 0; i < count; i++) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          week = WEEK_W'($urandom_range(0, WEEK_LAST));
          tow  = TOW_W'($urandom_range(0, TOW_WEEK - 1));
        end
        5, 6: begin
          week = WEEK_W'($urandom_range(0, WEEK_MAX));
          tow  = TOW_W'($urandom_range(0, TOW_MAX));
        end
        7, 8: begin
          // within 3 s of a UTC midnight
          week = WEEK_W'($urandom_range(0, WEEK_LAST));
          tow  = TOW_W'($urandom_range(1, 11) * 86400000 + dates.leap_s * 1000
                        - 3000 + $urandom_range(0, 5999));
        end
        default: begin
          pick = $urandom_range(0, 2);
          week = (pick == 0) ? '0 : (pick == 1) ? WEEK_W'(WEEK_LAST) : WEEK_MAX;
          case ($urandom_range(0, 4))
            0:       tow = '0;
            1:       tow = TOW_W'(999);
            2:       tow = TOW_W'(TOW_WEEK - 1);
            3:       tow = TOW_W'(TOW_WEEK);
            default: tow = TOW_MAX;
          endcase
        end
      endcase
      send_word(week, tow);
      if (i == pause_at) wait_results_done();
    end
  endtask

  initial begin
    dates = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset offset of 18 s: midnight, year end 2016, leap day 2100, extremes
    send_word(13'd0, 30'd0);
    send_word(13'd0, 30'd17999);
    send_word(13'd0, 30'd18000);
    send_word(13'd1930, 30'd17999);
    send_word(13'd1930, 30'd18000);
    send_word(13'd6269, 30'd86417999);
    send_word(13'd6269, 30'd86418000);
    send_word(13'd6269, 30'd172818000);
    send_word(WEEK_W'(WEEK_LAST), TOW_W'(TOW_WEEK - 1));
    send_word(13'd0, TOW_W'(TOW_WEEK));
    send_word(WEEK_MAX, TOW_MAX);
    send_word(13'h0AAA, 30'h2AAAAAAA);
    send_word(13'h1555, 30'h15555555);

    set_leap_offset(6'd63);
    send_word(13'd0, 30'd0);
    send_word(13'd0, 30'd62999);
    send_word(13'd0, 30'd63000);
    send_word(WEEK_MAX, TOW_MAX);
    random_words(200, 90);

    set_leap_offset(6'd0);
    send_word(13'd0, 30'd0);
    send_word(13'd1930, 30'd0);
    send_word(13'd1929, TOW_W'(TOW_WEEK - 1));
    random_words(200, 150);

    set_leap_offset(OFS_W'($urandom_range(1, 62)));
    random_words(200, 40);
    set_leap_offset(OFS_W'($urandom_range(0, 63)));
    random_words(200, 200);
    set_leap_offset(6'd18);
    random_words(250, 250);

    calm = 1'b1;
    set_leap_offset(OFS_W'($urandom_range(0, 63)));
    random_words(250, 250);

    wait_results_done();
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("Converted %0d words under %0d leap offset settings, %0d of them checked.",
             words_sent, offsets_used, dates.words_checked);
    $display("Time of week past one week in %0d words, weeks past %0d in %0d words.",
             past_week_tows, WEEK_LAST, late_weeks);
    if (dates.bad_words == 0 && dates.orphan_words == 0 && dates.pending() == 0) begin
      $display("PASS gps_time_to_utc_calendar_unit");
    end else begin
      $display("%0d wrong words, %0d unexpected words, %0d missing words",
               dates.bad_words, dates.orphan_words, dates.pending());
      $display("FAIL gps_time_to_utc_calendar_unit");
    end
    $finish;
  end

endmodule
